// File: rtl/smpc_pkg.sv
// Shared constants, types and register codes of the sliding-mode position controller.
package smpc_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_REGS  = 6;
  localparam int DATA_W    = 32;
  localparam int OUT_W     = 24;
  localparam int ADDR_W    = 5;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 64;
  localparam int S_W       = 66;
  localparam int LIN_W     = 67;
  localparam int L16_W     = LIN_W - FRAC_W;
  localparam int T_W       = 30;
  localparam int SQ_W      = 2 * T_W;
  localparam int N2_W      = SQ_W + 2;
  localparam int ROOT_W    = N2_W / 2;
  localparam int DIV_SH    = 15;
  localparam int NUM_W     = T_W + DIV_SH;
  localparam int DEN_W     = ROOT_W + 5;
  localparam int Q_W       = 11;
  localparam int SUM_W     = L16_W + 2;
  localparam int DAMP_Q16  = 131;

  localparam logic [DATA_W-1:0]        GAIN_RESET = 32'h0001_0000;
  localparam logic signed [OUT_W-1:0]  OUT_MAX    = 24'sd6553600;
  localparam logic signed [OUT_W-1:0]  OUT_MIN    = -24'sd6553600;

  typedef enum logic [2:0] {
    REG_INT_GAIN_X = 3'd0,
    REG_INT_GAIN_Y = 3'd1,
    REG_INT_GAIN_Z = 3'd2,
    REG_ERR_GAIN_X = 3'd3,
    REG_ERR_GAIN_Y = 3'd4,
    REG_ERR_GAIN_Z = 3'd5
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] q16_t;

  // Index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [NUM_AXES-1:0][DATA_W-1:0] int_err;
    logic [NUM_AXES-1:0][DATA_W-1:0] ref_val;
    logic [NUM_AXES-1:0][DATA_W-1:0] pos_err;
    logic [NUM_AXES-1:0][DATA_W-1:0] rate_err;
  } in_word_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][DATA_W-1:0] int_gain;
    logic [NUM_AXES-1:0][DATA_W-1:0] err_gain;
  } gains_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][T_W-1:0]   t;
    logic [NUM_AXES-1:0]            neg;
    logic                           nz;
    logic [NUM_AXES-1:0][L16_W-1:0] lin16;
  } side_t;

  typedef struct packed {
    logic [N2_W-1:0] n2;
    side_t           side;
  } front_out_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][OUT_W-1:0] drive;
  } out_word_t;

endpackage

// File: rtl/smpc_if.sv
// Valid/ready channel interfaces for the input and result words.
interface smpc_in_if;
  import smpc_pkg::*;
  logic valid;
  logic ready;
  q16_t int_err_x;
  q16_t int_err_y;
  q16_t int_err_z;
  q16_t ref_x;
  q16_t ref_y;
  q16_t ref_z;
  q16_t pos_err_x;
  q16_t pos_err_y;
  q16_t pos_err_z;
  q16_t rate_err_x;
  q16_t rate_err_y;
  q16_t rate_err_z;
  modport source (
    output valid, int_err_x, int_err_y, int_err_z, ref_x, ref_y, ref_z,
           pos_err_x, pos_err_y, pos_err_z, rate_err_x, rate_err_y, rate_err_z,
    input  ready
  );
  modport sink (
    input  valid, int_err_x, int_err_y, int_err_z, ref_x, ref_y, ref_z,
           pos_err_x, pos_err_y, pos_err_z, rate_err_x, rate_err_y, rate_err_z,
    output ready
  );
endinterface

interface smpc_out_if;
  import smpc_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] drive_x;
  logic signed [OUT_W-1:0] drive_y;
  logic signed [OUT_W-1:0] drive_z;
  modport source (output valid, drive_x, drive_y, drive_z, input ready);
  modport sink (input valid, drive_x, drive_y, drive_z, output ready);
endinterface

// File: rtl/smpc_cfg.sv
// APB-style gain register file.
module smpc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smpc_pkg::ADDR_W-1:0] paddr,
  input  logic [smpc_pkg::DATA_W-1:0] pwdata,
  output logic [smpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output smpc_pkg::gains_t            gains
);
  import smpc_pkg::*;

  logic [NUM_REGS-1:0][DATA_W-1:0] regs_r, regs_nxt;
  logic [2:0]                      idx;
  logic                            wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    // drop writes beyond the last register
    if (wr && idx <= REG_ERR_GAIN_Z) begin
      regs_nxt[idx] = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= {NUM_REGS{GAIN_RESET}};
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign prdata = (idx <= REG_ERR_GAIN_Z) ? regs_r[idx] : '0;

  assign gains.int_gain[0] = regs_r[REG_INT_GAIN_X];
  assign gains.int_gain[1] = regs_r[REG_INT_GAIN_Y];
  assign gains.int_gain[2] = regs_r[REG_INT_GAIN_Z];
  assign gains.err_gain[0] = regs_r[REG_ERR_GAIN_X];
  assign gains.err_gain[1] = regs_r[REG_ERR_GAIN_Y];
  assign gains.err_gain[2] = regs_r[REG_ERR_GAIN_Z];

endmodule

// File: rtl/smpc_front.sv
// Front pipeline: products, surface and linear sums, normalization, squared norm.
module smpc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smpc_pkg::in_word_t    in_word,
  input  smpc_pkg::gains_t      gains,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smpc_pkg::front_out_t  out_word
);
  import smpc_pkg::*;

  localparam int NST = 7;
  localparam logic signed [LIN_W-1:0] RND_HALF = LIN_W'(32768);

  typedef logic [NUM_AXES-1:0][S_W-1:0] mag3_t;

  // Shift all magnitudes left by k when the top k bits of their OR are clear.
  function automatic mag3_t nstep(input mag3_t m, input int k);
    logic [S_W-1:0] o;
    mag3_t          r;
    o = m[0] | m[1] | m[2];
    r = m;
    if ((o >> (S_W - k)) == '0) begin
      for (int i = 0; i < NUM_AXES; i++) r[i] = m[i] << k;
    end
    return r;
  endfunction

  logic [NST-1:0] v_r, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: products
  logic signed [PROD_W-1:0] gie_r [NUM_AXES];
  logic signed [PROD_W-1:0] ge_r  [NUM_AXES];
  logic signed [PROD_W-1:0] he_r  [NUM_AXES];
  logic signed [PROD_W-1:0] gr_r  [NUM_AXES];
  logic signed [DATA_W-1:0] de_r  [NUM_AXES];

  // stage 1: surface and two halves of the linear term
  logic signed [S_W-1:0]   s_c  [NUM_AXES];
  logic signed [LIN_W-1:0] la_c [NUM_AXES];
  logic signed [LIN_W-1:0] lb_c [NUM_AXES];
  logic signed [LIN_W-1:0] d_c  [NUM_AXES];
  logic signed [LIN_W-1:0] h3_c [NUM_AXES];
  logic signed [S_W-1:0]   s_r  [NUM_AXES];
  logic signed [LIN_W-1:0] la_r [NUM_AXES];
  logic signed [LIN_W-1:0] lb_r [NUM_AXES];

  // stage 2: rounded linear term, magnitudes
  logic signed [LIN_W-1:0] lsum_c [NUM_AXES];
  mag3_t                   mag_c, mag_r;

  // stages 3..4: normalization
  mag3_t                   m3_r, m4_c;
  logic                    nz_c;

  // stages 5..6
  logic [SQ_W-1:0]         sq_r [NUM_AXES];
  logic [N2_W-1:0]         n2_r;

  side_t                   sd_r [2:NST-1];
  side_t                   sd2_c, sd3_c, sd4_c;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      d_c[i]  = LIN_W'(de_r[i]) <<< FRAC_W;
      s_c[i]  = S_W'(gie_r[i]) + S_W'(he_r[i]) + S_W'(d_c[i]);
      la_c[i] = LIN_W'(ge_r[i]) - (LIN_W'(gie_r[i]) <<< 1) - LIN_W'(gr_r[i]);
      h3_c[i] = LIN_W'(he_r[i]) + d_c[i];
      lb_c[i] = -((h3_c[i] <<< 1) + h3_c[i]);
      lsum_c[i] = la_r[i] + lb_r[i] + RND_HALF;
      mag_c[i]  = s_r[i][S_W-1] ? S_W'(-s_r[i]) : S_W'(s_r[i]);
    end
    nz_c = |(mag_r[0] | mag_r[1] | mag_r[2]);
    m4_c = nstep(nstep(nstep(m3_r, 4), 2), 1);

    sd2_c = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sd2_c.lin16[i] = lsum_c[i][LIN_W-1:FRAC_W];
      sd2_c.neg[i]   = s_r[i][S_W-1];
    end
    sd3_c    = sd_r[2];
    sd3_c.nz = nz_c;
    sd4_c    = sd_r[3];
    for (int i = 0; i < NUM_AXES; i++) begin
      sd4_c.t[i] = m4_c[i][S_W-1 -: T_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gie_r[i] <= $signed(gains.int_gain[i]) * $signed(in_word.int_err[i]);
        ge_r[i]  <= $signed(gains.int_gain[i]) * $signed(in_word.pos_err[i]);
        he_r[i]  <= $signed(gains.err_gain[i]) * $signed(in_word.pos_err[i]);
        gr_r[i]  <= $signed(gains.int_gain[i]) * $signed(in_word.ref_val[i]);
        de_r[i]  <= $signed(in_word.rate_err[i]);
      end
    end
    if (en[1]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s_r[i]  <= s_c[i];
        la_r[i] <= la_c[i];
        lb_r[i] <= lb_c[i];
      end
    end
    if (en[2]) begin
      mag_r   <= mag_c;
      sd_r[2] <= sd2_c;
    end
    if (en[3]) begin
      m3_r    <= nstep(nstep(nstep(nstep(mag_r, 64), 32), 16), 8);
      sd_r[3] <= sd3_c;
    end
    if (en[4]) begin
      sd_r[4] <= sd4_c;
    end
    if (en[5]) begin
      sd_r[5] <= sd_r[4];
      for (int i = 0; i < NUM_AXES; i++) begin
        sq_r[i] <= SQ_W'(sd_r[4].t[i]) * SQ_W'(sd_r[4].t[i]);
      end
    end
    if (en[6]) begin
      sd_r[6] <= sd_r[5];
      n2_r    <= N2_W'(sq_r[0]) + N2_W'(sq_r[1]) + N2_W'(sq_r[2]);
    end
  end

  assign out_word.n2   = n2_r;
  assign out_word.side = sd_r[NST-1];

endmodule

// File: rtl/smpc_sqrt.sv
// Pipelined integer square root, two result bits per stage.
module smpc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  smpc_pkg::front_out_t        in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [smpc_pkg::ROOT_W-1:0] root,
  output smpc_pkg::side_t             side
);
  import smpc_pkg::*;

  localparam int PER   = 2;
  localparam int NST   = (ROOT_W + PER - 1) / PER;
  localparam int REM_W = ROOT_W + 4;

  logic [NST-1:0] v_r, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  logic [REM_W-1:0]  rem_q  [NST];
  logic [ROOT_W-1:0] root_q [NST];
  logic [N2_W-1:0]   op_q   [NST];
  side_t             sd_q   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [REM_W-1:0]  rem_i, rem_c, rem_r;
    logic [ROOT_W-1:0] root_i, root_c, root_r;
    logic [N2_W-1:0]   op_i, op_c, op_r;
    side_t             sd_i, sd_r;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign op_i   = in_word.n2;
      assign sd_i   = in_word.side;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign op_i   = op_q[k-1];
      assign sd_i   = sd_q[k-1];
    end

    always_comb begin
      logic [REM_W-1:0] acc;
      logic [REM_W-1:0] trial;
      acc    = '0;
      trial  = '0;
      rem_c  = rem_i;
      root_c = root_i;
      op_c   = op_i;
      for (int j = 0; j < PER; j++) begin
        if (k * PER + j < ROOT_W) begin
          acc   = {rem_c[REM_W-3:0], op_c[N2_W-1 -: 2]};
          trial = REM_W'({root_c, 2'b01});
          op_c  = op_c << 2;
          if (acc >= trial) begin
            rem_c  = acc - trial;
            root_c = {root_c[ROOT_W-2:0], 1'b1};
          end else begin
            rem_c  = acc;
            root_c = {root_c[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r  <= rem_c;
        root_r <= root_c;
        op_r   <= op_c;
        sd_r   <= sd_i;
      end
    end

    assign rem_q[k]  = rem_r;
    assign root_q[k] = root_r;
    assign op_q[k]   = op_r;
    assign sd_q[k]   = sd_r;
  end

  assign root = root_q[NST-1];
  assign side = sd_q[NST-1];

endmodule

// File: rtl/smpc_div.sv
// Pipelined switching-term divider per axis, then sum and clamp into the result register.
module smpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [smpc_pkg::ROOT_W-1:0] root,
  input  smpc_pkg::side_t             side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output smpc_pkg::out_word_t         out_word
);
  import smpc_pkg::*;

  localparam int PER   = 2;
  localparam int DST   = (Q_W + PER - 1) / PER;
  localparam int NST   = DST + 2;
  localparam int REM_W = DEN_W + Q_W - 1;

  typedef logic [NUM_AXES-1:0][REM_W-1:0] rem3_t;
  typedef logic [NUM_AXES-1:0][Q_W-1:0]   q3_t;

  logic [NST-1:0] v_r, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  rem3_t            rem_q [DST+1];
  q3_t              q_q   [DST+1];
  logic [DEN_W-1:0] den_q [DST+1];
  side_t            sd_q  [DST+1];

  // stage 0: divisor 25*R, numerators t << 15
  rem3_t            rem0_r;
  logic [DEN_W-1:0] den0_r, den0_c;
  side_t            sd0_r;

  assign den0_c = (DEN_W'(root) << 4) + (DEN_W'(root) << 3) + DEN_W'(root);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      den0_r <= den0_c;
      sd0_r  <= side;
      for (int i = 0; i < NUM_AXES; i++) begin
        rem0_r[i] <= REM_W'({side.t[i], {DIV_SH{1'b0}}});
      end
    end
  end

  assign rem_q[0] = rem0_r;
  assign q_q[0]   = '0;
  assign den_q[0] = den0_r;
  assign sd_q[0]  = sd0_r;

  // stages 1..DST: restoring division, quotient MSB first
  for (genvar k = 1; k <= DST; k++) begin : g_stage
    rem3_t            rem_c, rem_r;
    q3_t              q_c, q_r;
    logic [DEN_W-1:0] den_r;
    side_t            sd_r;

    always_comb begin
      logic [REM_W-1:0] sh;
      int               b;
      sh    = '0;
      b     = 0;
      rem_c = rem_q[k-1];
      q_c   = q_q[k-1];
      for (int j = 0; j < PER; j++) begin
        b = Q_W - 1 - ((k - 1) * PER + j);
        if (b >= 0) begin
          sh = REM_W'(den_q[k-1]) << b;
          for (int i = 0; i < NUM_AXES; i++) begin
            if (rem_c[i] >= sh) begin
              rem_c[i] = rem_c[i] - sh;
              q_c[i]   = {q_c[i][Q_W-2:0], 1'b1};
            end else begin
              q_c[i]   = {q_c[i][Q_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r <= rem_c;
        q_r   <= q_c;
        den_r <= den_q[k-1];
        sd_r  <= sd_q[k-1];
      end
    end

    assign rem_q[k] = rem_r;
    assign q_q[k]   = q_r;
    assign den_q[k] = den_r;
    assign sd_q[k]  = sd_r;
  end

  // last stage: add switching term, clamp
  localparam logic signed [SUM_W-1:0] DAMP_S = SUM_W'(DAMP_Q16);

  logic signed [SUM_W-1:0]         qs_c  [NUM_AXES];
  logic signed [SUM_W-1:0]         n_c   [NUM_AXES];
  logic signed [SUM_W-1:0]         sum_c [NUM_AXES];
  logic [NUM_AXES-1:0][OUT_W-1:0]  drv_c, drive_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      qs_c[i] = $signed(SUM_W'(q_q[DST][i]));
      if (!sd_q[DST].nz) begin
        n_c[i] = -DAMP_S;
      end else if (sd_q[DST].neg[i]) begin
        n_c[i] = qs_c[i] - DAMP_S;
      end else begin
        n_c[i] = -qs_c[i] - DAMP_S;
      end
      sum_c[i] = SUM_W'($signed(sd_q[DST].lin16[i])) + n_c[i];
      if (sum_c[i] > OUT_MAX) begin
        drv_c[i] = OUT_MAX;
      end else if (sum_c[i] < OUT_MIN) begin
        drv_c[i] = OUT_MIN;
      end else begin
        drv_c[i] = sum_c[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) drive_r <= drv_c;
  end

  assign out_word.drive = drive_r;

endmodule

// File: rtl/sliding_mode_position_control_core.sv
// Three-axis sliding-mode position controller: each input word gives one word of
// drive commands. The datapath is a 31-stage pipeline (7 stages of products, sums
// and normalization, 16 stages of square root at two root bits per stage, and 8
// stages for the switching term: divisor setup, six division stages at two quotient
// bits per stage, and the final sum and clamp). One word enters per cycle for as
// long as the result side keeps taking words. The pipeline collapses bubbles: a
// stalled output holds only the stages behind it that are full. The six gain
// registers sit at byte addresses 0x00..0x14 and reset to 1.0; write them only
// while no word is in flight.
module sliding_mode_position_control_core (
  input  logic                        clk,
  input  logic                        rst_n,
  smpc_in_if.sink                     in_chan,
  smpc_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smpc_pkg::ADDR_W-1:0] paddr,
  input  logic [smpc_pkg::DATA_W-1:0] pwdata,
  output logic [smpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import smpc_pkg::*;

  gains_t     gains;
  in_word_t   in_word;
  front_out_t front_word;
  side_t      sq_side;
  out_word_t  out_word;

  logic              front_valid, front_ready;
  logic              sq_valid, sq_ready;
  logic [ROOT_W-1:0] sq_root;

  // Gain registers.
  smpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  // Gather the axis fields; index 0 is x.
  assign in_word.int_err  = {in_chan.int_err_z, in_chan.int_err_y, in_chan.int_err_x};
  assign in_word.ref_val  = {in_chan.ref_z, in_chan.ref_y, in_chan.ref_x};
  assign in_word.pos_err  = {in_chan.pos_err_z, in_chan.pos_err_y, in_chan.pos_err_x};
  assign in_word.rate_err = {in_chan.rate_err_z, in_chan.rate_err_y, in_chan.rate_err_x};

  // Products, surface s and linear term, then direction of s scaled to 30 bits
  // and its squared length.
  smpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_word   (in_word),
    .gains     (gains),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_word  (front_word)
  );

  // Length of the scaled surface vector.
  smpc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_word   (front_word),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root      (sq_root),
    .side      (sq_side)
  );

  // Switching term 0.02 * t / R per axis, offset, sum with the linear term, clamp.
  smpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .root      (sq_root),
    .side      (sq_side),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_word  (out_word)
  );

  assign out_chan.drive_x = out_word.drive[0];
  assign out_chan.drive_y = out_word.drive[1];
  assign out_chan.drive_z = out_word.drive[2];

`ifndef SYNTHESIS
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.drive_x <= OUT_MAX && out_chan.drive_x >= OUT_MIN &&
                        out_chan.drive_y <= OUT_MAX && out_chan.drive_y >= OUT_MIN &&
                        out_chan.drive_z <= OUT_MAX && out_chan.drive_z >= OUT_MIN))
    else $error("drive out of clamp range");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while result side is ready");

  a_gain_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_INT_GAIN_X)
      |=> gains.int_gain[0] == $past(pwdata))
    else $error("gain write lost");
`endif

endmodule
